/* rtl/core/srg_pkg.sv */
// srg_pkg: constants and command codes of the subtractive random generator
// no dependencies; imported by subtractive_random_generator, srg_checker and tb_subtractive_random_generator

package srg_pkg;

   // table geometry
   localparam int TABLE_WORDS = 55;
   localparam int ADDR_W      = $clog2(TABLE_WORDS);
   localparam int WORD_W      = 30;
   localparam int PTR_W       = 6;
   localparam int SEED_W      = 29;

   // arithmetic constants of the scheme
   localparam logic [WORD_W-1:0] MODULUS      = WORD_W'(1000000000);
   localparam logic [WORD_W-1:0] SEED_BASE    = WORD_W'(161803398);
   localparam logic [ADDR_W-1:0] SPREAD_STEP  = ADDR_W'(21);
   localparam logic [ADDR_W-1:0] MIX_OFFSET   = ADDR_W'(31);
   localparam logic [PTR_W-1:0]  SECOND_START = PTR_W'(31);
   localparam logic [1:0]        MIX_PASSES_M1 = 2'd3;

   // slot numbers of a status dump
   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(TABLE_WORDS - 1);
   localparam logic [PTR_W-1:0]  SLOT_FIRST_PTR  = PTR_W'(TABLE_WORDS);
   localparam logic [PTR_W-1:0]  SLOT_SECOND_PTR = PTR_W'(TABLE_WORDS + 1);

   // request commands
   localparam logic [1:0] CMD_SEED    = 2'd0;
   localparam logic [1:0] CMD_NEXT    = 2'd1;
   localparam logic [1:0] CMD_SAVE    = 2'd2;
   localparam logic [1:0] CMD_RESTORE = 2'd3;

endpackage

/* rtl/core/subtractive_random_generator.sv */
// subtractive_random_generator: lagged subtractive generator over a 55 word table
// depends on srg_pkg
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+--------------------------------
//   req_     | in        | req_tvalid / req_tready | tuser command, tdata seed/status
//   rsp_     | out       | rsp_tvalid / rsp_tready | tdata value/index, tlast
//
// next: accept, table read, then subtract and write back, through the single shared
// mod 10^9 subtractor and the registered table read.
// seed: accept, start word, 54 spread steps, then 4 x 55 mixing steps, each a read
// followed by a subtract and write.
// save: accept, then the 55 words, each read and then sent, then the two pointers.
// restore: written as it is accepted. reset clears the table through per-word valid
// bits at once.
// a stalled response holds the sequencer; requests are taken only in the idle state.

module subtractive_random_generator
   import srg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [28:0] seed_value, [34:29] status_index, [64:35] status_value, [71:65] zero
   input  logic [71:0] req_tdata,
   // [1:0] command
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [29:0] result_value, [35:30] result_index, [39:36] zero
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast
);

   // sequencer states
   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_SEED_START = 4'd1;
   localparam logic [3:0] S_SPREAD     = 4'd2;
   localparam logic [3:0] S_MIX_RD     = 4'd3;
   localparam logic [3:0] S_MIX_WR     = 4'd4;
   localparam logic [3:0] S_NEXT_RD    = 4'd5;
   localparam logic [3:0] S_NEXT_WR    = 4'd6;
   localparam logic [3:0] S_SAVE_RD    = 4'd7;
   localparam logic [3:0] S_SAVE_WR    = 4'd8;
   localparam logic [3:0] S_SAVE_PTR   = 4'd9;

   // request fields
   logic [1:0]        req_command;
   logic [SEED_W-1:0] req_seed;
   logic [PTR_W-1:0]  req_index;
   logic [WORD_W-1:0] req_value;

   assign req_command = req_tuser;
   assign req_seed    = req_tdata[28:0];
   assign req_index   = req_tdata[34:29];
   assign req_value   = req_tdata[64:35];

   // state registers
   logic [3:0]        state_ff, state_in;
   logic [PTR_W-1:0]  first_ptr_ff, first_ptr_in;
   logic [PTR_W-1:0]  second_ptr_ff, second_ptr_in;
   logic [WORD_W-1:0] prev_ff, prev_in;
   logic [WORD_W-1:0] cur_ff, cur_in;
   logic [ADDR_W-1:0] slot_ff, slot_in;
   logic [ADDR_W-1:0] step_ff, step_in;
   logic [ADDR_W-1:0] other_ff, other_in;
   logic [1:0]        pass_ff, pass_in;
   logic [PTR_W-1:0]  slot_out_ff, slot_out_in;

   // table memory with registered reads
   logic [WORD_W-1:0]      table_mem [TABLE_WORDS];
   logic [TABLE_WORDS-1:0] word_valid_ff;
   logic [WORD_W-1:0]      rd_a_ff, rd_b_ff;
   logic                   rd_a_ok_ff, rd_b_ok_ff;
   logic [WORD_W-1:0]      rd_a, rd_b;
   logic [ADDR_W-1:0]      addr_a, addr_b;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [WORD_W-1:0]      wr_data;

   // response register
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_value_ff;
   logic [PTR_W-1:0]  rsp_index_ff;
   logic              rsp_last_ff;
   logic              rsp_load;
   logic [WORD_W-1:0] rsp_value_in;
   logic [PTR_W-1:0]  rsp_index_in;
   logic              rsp_last_in;
   logic              rsp_free;

   // shared subtract unit, (a - b) mod 10^9
   logic [WORD_W-1:0] sub_a, sub_b, sub_res;
   logic [WORD_W:0]   sub_diff;

   // seed start word and misc helpers
   logic [SEED_W-1:0] seed_mag;
   logic [WORD_W-1:0] start_diff, start_word;
   logic [ADDR_W:0]   slot_sum;
   logic [WORD_W-1:0] restore_word;
   logic              req_fire;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      if (p == '0 || p >= PTR_W'(TABLE_WORDS)) begin
         return PTR_W'(1);
      end
      return p + PTR_W'(1);
   endfunction

   function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] a);
      if (a == LAST_WORD) begin
         return '0;
      end
      return a + ADDR_W'(1);
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // words never written read as zero
   assign rd_a = rd_a_ok_ff ? rd_a_ff : '0;
   assign rd_b = rd_b_ok_ff ? rd_b_ff : '0;

   // shared subtractor
   assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_res  = sub_diff[WORD_W] ? (sub_diff[WORD_W-1:0] + MODULUS)
                                      : sub_diff[WORD_W-1:0];

   // seed magnitude and start word
   assign seed_mag   = req_seed[SEED_W-1] ? (~req_seed + SEED_W'(1)) : req_seed;
   assign start_diff = SEED_BASE - prev_ff;
   assign start_word = start_diff[WORD_W-1] ? (~start_diff + WORD_W'(1)) : start_diff;

   // spread position, 21 steps on modulo 55
   assign slot_sum = {1'b0, slot_ff} + {1'b0, SPREAD_STEP};

   // restored word reduced once
   assign restore_word = (req_value >= MODULUS) ? (req_value - MODULUS) : req_value;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      first_ptr_in  = first_ptr_ff;
      second_ptr_in = second_ptr_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      slot_in       = slot_ff;
      step_in       = step_ff;
      other_in      = other_ff;
      pass_in       = pass_ff;
      slot_out_in   = slot_out_ff;
      addr_a        = '0;
      addr_b        = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      sub_a         = rd_a;
      sub_b         = rd_b;
      rsp_load      = 1'b0;
      rsp_value_in  = '0;
      rsp_index_in  = '0;
      rsp_last_in   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_command)
                  CMD_SEED: begin
                     prev_in  = WORD_W'(seed_mag);
                     state_in = S_SEED_START;
                  end
                  CMD_NEXT: begin
                     first_ptr_in  = advance(first_ptr_ff);
                     second_ptr_in = advance(second_ptr_ff);
                     state_in      = S_NEXT_RD;
                  end
                  CMD_SAVE: begin
                     slot_out_in = '0;
                     state_in    = S_SAVE_RD;
                  end
                  CMD_RESTORE: begin
                     if (req_index < PTR_W'(TABLE_WORDS)) begin
                        wr_en   = 1'b1;
                        wr_addr = req_index[ADDR_W-1:0];
                        wr_data = restore_word;
                     end else if (req_index == SLOT_FIRST_PTR) begin
                        first_ptr_in = req_value[PTR_W-1:0];
                     end else if (req_index == SLOT_SECOND_PTR) begin
                        second_ptr_in = req_value[PTR_W-1:0];
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         // last word takes the start value, spread begins at slot 21
         S_SEED_START: begin
            wr_en    = 1'b1;
            wr_addr  = LAST_WORD;
            wr_data  = start_word;
            prev_in  = start_word;
            cur_in   = WORD_W'(1);
            slot_in  = SPREAD_STEP;
            step_in  = ADDR_W'(1);
            state_in = S_SPREAD;
         end
         // one spread word per cycle, next word through the subtractor
         S_SPREAD: begin
            wr_en   = 1'b1;
            wr_addr = slot_ff - ADDR_W'(1);
            wr_data = cur_ff;
            sub_a   = prev_ff;
            sub_b   = cur_ff;
            prev_in = cur_ff;
            cur_in  = sub_res;
            slot_in = (slot_sum >= (ADDR_W+1)'(TABLE_WORDS))
                      ? ADDR_W'(slot_sum - (ADDR_W+1)'(TABLE_WORDS))
                      : slot_sum[ADDR_W-1:0];
            step_in = step_ff + ADDR_W'(1);
            if (step_ff == LAST_WORD) begin
               step_in  = '0;
               other_in = MIX_OFFSET;
               pass_in  = '0;
               state_in = S_MIX_RD;
            end
         end
         S_MIX_RD: begin
            addr_a   = step_ff;
            addr_b   = other_ff;
            state_in = S_MIX_WR;
         end
         // word minus the word 31 places on, written back
         S_MIX_WR: begin
            addr_a   = step_ff;
            addr_b   = other_ff;
            wr_en    = 1'b1;
            wr_addr  = step_ff;
            wr_data  = sub_res;
            step_in  = wrap_inc(step_ff);
            other_in = wrap_inc(other_ff);
            state_in = S_MIX_RD;
            if (step_ff == LAST_WORD) begin
               pass_in = pass_ff + 2'd1;
               if (pass_ff == MIX_PASSES_M1) begin
                  first_ptr_in  = '0;
                  second_ptr_in = SECOND_START;
                  state_in      = S_IDLE;
               end
            end
         end
         S_NEXT_RD: begin
            addr_a   = ADDR_W'(first_ptr_ff - PTR_W'(1));
            addr_b   = ADDR_W'(second_ptr_ff - PTR_W'(1));
            state_in = S_NEXT_WR;
         end
         S_NEXT_WR: begin
            addr_a = ADDR_W'(first_ptr_ff - PTR_W'(1));
            addr_b = ADDR_W'(second_ptr_ff - PTR_W'(1));
            if (rsp_free) begin
               wr_en        = 1'b1;
               wr_addr      = addr_a;
               wr_data      = sub_res;
               rsp_load     = 1'b1;
               rsp_value_in = sub_res;
               rsp_index_in = '0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SAVE_RD: begin
            addr_a   = slot_out_ff[ADDR_W-1:0];
            state_in = S_SAVE_WR;
         end
         S_SAVE_WR: begin
            addr_a = slot_out_ff[ADDR_W-1:0];
            if (rsp_free) begin
               rsp_load     = 1'b1;
               rsp_value_in = rd_a;
               rsp_index_in = slot_out_ff;
               slot_out_in  = slot_out_ff + PTR_W'(1);
               state_in     = (slot_out_ff == PTR_W'(LAST_WORD)) ? S_SAVE_PTR : S_SAVE_RD;
            end
         end
         // both pointers follow the table words
         S_SAVE_PTR: begin
            if (rsp_free) begin
               rsp_load     = 1'b1;
               rsp_value_in = (slot_out_ff == SLOT_FIRST_PTR) ? WORD_W'(first_ptr_ff)
                                                              : WORD_W'(second_ptr_ff);
               rsp_index_in = slot_out_ff;
               rsp_last_in  = (slot_out_ff == SLOT_SECOND_PTR);
               slot_out_in  = slot_out_ff + PTR_W'(1);
               if (slot_out_ff == SLOT_SECOND_PTR) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         first_ptr_ff  <= '0;
         second_ptr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         word_valid_ff <= '0;
      end else begin
         state_ff      <= state_in;
         first_ptr_ff  <= first_ptr_in;
         second_ptr_ff <= second_ptr_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            word_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      slot_ff     <= slot_in;
      step_ff     <= step_in;
      other_ff    <= other_in;
      pass_ff     <= pass_in;
      slot_out_ff <= slot_out_in;
      if (rsp_load) begin
         rsp_value_ff <= rsp_value_in;
         rsp_index_ff <= rsp_index_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // table memory, one write and two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rd_a_ff    <= table_mem[addr_a];
      rd_b_ff    <= table_mem[addr_b];
      rd_a_ok_ff <= word_valid_ff[addr_a];
      rd_b_ok_ff <= word_valid_ff[addr_b];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_index_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

   // checks on the sequencer
   a_seed_ptrs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MIX_WR && step_ff == LAST_WORD && pass_ff == MIX_PASSES_M1)
      |=> (first_ptr_ff == '0 && second_ptr_ff == SECOND_START))
      else $error("pointers not set after seeding");

   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr < ADDR_W'(TABLE_WORDS)))
      else $error("table write outside the table");

   a_next_ptrs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NEXT_RD) |-> (first_ptr_ff != '0 && second_ptr_ff != '0
         && first_ptr_ff <= PTR_W'(TABLE_WORDS) && second_ptr_ff <= PTR_W'(TABLE_WORDS)))
      else $error("advanced pointer outside 1..55");

   a_spread_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SPREAD) |-> (slot_ff != '0 && slot_ff < ADDR_W'(TABLE_WORDS)))
      else $error("spread slot out of range");

   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_index_ff == '0 || rsp_index_ff == SLOT_SECOND_PTR))
      else $error("last response on an unexpected slot");

endmodule

/* sim/srg_checker.sv */
// srg_checker: watches both streams of the subtractive random generator, keeps a shadow
// of its lag table and pointers, and compares every response with the predicted one
// depends on srg_pkg for the command codes and table geometry

module srg_checker
   import srg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // [28:0] seed_value, [34:29] status_index, [64:35] status_value, [71:65] zero
   input  logic [71:0] req_tdata,
   // [1:0] command
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [29:0] result_value, [35:30] result_index, [39:36] zero
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          pending_count,
   output int          checked_count
);

   timeunit 1ns;
   timeprecision 1ps;

   // spread step on one-based slots; mixing lag from a one-based word to the zero-based slot of its partner
   localparam int SPREAD = 21;
   localparam int MIX_LAG = 30;
   localparam int PASSES = 4;
   localparam longint MOD_10E9 = 64'd1000000000;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic [PTR_W-1:0]  index;
      logic              last;
   } rng_output_type;

   // shadow state of the generator
   logic [WORD_W-1:0] shadow_table [TABLE_WORDS];
   logic [PTR_W-1:0]  shadow_first;
   logic [PTR_W-1:0]  shadow_second;

   rng_output_type awaited_outputs [$];
   int             fails = 0;
   int             checked = 0;

   // difference of two table words modulo 10^9
   function automatic logic [WORD_W-1:0] mod_sub(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) begin
         d += MOD_10E9;
      end
      return WORD_W'(d);
   endfunction

   function automatic logic [PTR_W-1:0] step_pointer(input logic [PTR_W-1:0] p);
      if (p == '0 || p >= PTR_W'(TABLE_WORDS)) begin
         return PTR_W'(1);
      end
      return p + PTR_W'(1);
   endfunction

   // table fill from the seed magnitude, spread, then mixing passes
   task automatic fill_from_seed(input logic [SEED_W-1:0] raw);
      longint mag;
      longint start;
      logic [WORD_W-1:0] cur;
      logic [WORD_W-1:0] prev;
      logic [WORD_W-1:0] nxt;
      int slot;
      if (raw[SEED_W-1]) begin
         mag = (longint'(1) << SEED_W) - longint'(raw);
      end else begin
         mag = longint'(raw);
      end
      start = longint'(SEED_BASE) - mag;
      if (start < 0) begin
         start = -start;
      end
      start = start % MOD_10E9;
      prev = WORD_W'(start);
      cur = WORD_W'(1);
      shadow_table[TABLE_WORDS-1] = prev;
      for (int i = 1; i < TABLE_WORDS; i++) begin
         slot = (SPREAD * i) % TABLE_WORDS;
         shadow_table[slot-1] = cur;
         nxt = mod_sub(prev, cur);
         prev = cur;
         cur = nxt;
      end
      for (int pass = 0; pass < PASSES; pass++) begin
         for (int i = 1; i <= TABLE_WORDS; i++) begin
            slot = (i + MIX_LAG) % TABLE_WORDS;
            shadow_table[i-1] = mod_sub(shadow_table[i-1], shadow_table[slot]);
         end
      end
      shadow_first = '0;
      shadow_second = SECOND_START;
   endtask

   // apply one accepted request to the shadow and queue what it should produce
   task automatic mirror_request(input logic [1:0] cmd, input logic [71:0] data);
      logic [SEED_W-1:0] seed;
      logic [PTR_W-1:0]  idx;
      logic [WORD_W-1:0] val;
      logic [WORD_W-1:0] number;
      seed = data[28:0];
      idx = data[34:29];
      val = data[64:35];
      case (cmd)
         CMD_SEED: begin
            fill_from_seed(seed);
         end
         CMD_NEXT: begin
            shadow_first = step_pointer(shadow_first);
            shadow_second = step_pointer(shadow_second);
            number = mod_sub(shadow_table[shadow_first-1], shadow_table[shadow_second-1]);
            shadow_table[shadow_first-1] = number;
            awaited_outputs.push_back('{number, '0, 1'b1});
         end
         CMD_SAVE: begin
            for (int k = 0; k < TABLE_WORDS; k++) begin
               awaited_outputs.push_back('{shadow_table[k], PTR_W'(k), 1'b0});
            end
            awaited_outputs.push_back('{WORD_W'(shadow_first), SLOT_FIRST_PTR, 1'b0});
            awaited_outputs.push_back('{WORD_W'(shadow_second), SLOT_SECOND_PTR, 1'b1});
         end
         CMD_RESTORE: begin
            if (idx < PTR_W'(TABLE_WORDS)) begin
               // words of 10^9 and above lose one modulus
               if (val >= MODULUS) begin
                  val = val - MODULUS;
               end
               shadow_table[idx] = val;
            end else if (idx == SLOT_FIRST_PTR) begin
               shadow_first = val[PTR_W-1:0];
            end else if (idx == SLOT_SECOND_PTR) begin
               shadow_second = val[PTR_W-1:0];
            end
         end
         default: begin
         end
      endcase
   endtask

   // compare one accepted response with the oldest prediction
   task automatic check_response();
      rng_output_type want;
      logic [WORD_W-1:0] got_value;
      logic [PTR_W-1:0]  got_index;
      got_value = rsp_tdata[29:0];
      got_index = rsp_tdata[35:30];
      checked++;
      if (awaited_outputs.size() == 0) begin
         if (fails < 10) begin
            $display("unexpected response %0d: value %0d index %0d last %0b",
                     checked, got_value, got_index, rsp_tlast);
         end
         fails++;
      end else begin
         want = awaited_outputs.pop_front();
         if (got_value !== want.value || got_index !== want.index ||
             rsp_tlast !== want.last || rsp_tdata[39:36] !== 4'd0) begin
            if (fails < 10) begin
               $display("response %0d differs: value %0d/%0d index %0d/%0d last %0b/%0b pad %h",
                        checked, want.value, got_value, want.index, got_index,
                        want.last, rsp_tlast, rsp_tdata[39:36]);
            end
            fails++;
         end
      end
   endtask

   // observe both channels at each edge, responses first
   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TABLE_WORDS; k++) begin
            shadow_table[k] = '0;
         end
         shadow_first = '0;
         shadow_second = '0;
         awaited_outputs.delete();
      end else begin
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            check_response();
         end
         if (req_tvalid === 1'b1 && req_tready === 1'b1) begin
            mirror_request(req_tuser, req_tdata);
         end
      end
      mismatch_count <= fails;
      pending_count <= awaited_outputs.size();
      checked_count <= checked;
   end

endmodule

/* sim/tb_subtractive_random_generator.sv */
// tb_subtractive_random_generator: request stimulus and verdict for the generator
// depends on srg_pkg, subtractive_random_generator and srg_checker

module tb_subtractive_random_generator;
   import srg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 230;
   localparam int SETTLE_CYCLES = 600;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [1:0]  req_tuser = CMD_SEED;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   int mismatch_count;
   int pending_count;
   int checked_count;

   // request tallies per command
   int seeds_sent;
   int nexts_sent;
   int saves_sent;
   int restores_sent;
   int sent_total;
   bit idling_on = 1'b1;

   subtractive_random_generator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   srg_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= !(idling_on && $urandom_range(99) < 23);
   end

   // overall time limit
   initial begin
      #2_000_000;
      $display("tb_subtractive_random_generator NOT OK");
      $finish;
   end

   function automatic logic [71:0] pack_request(input logic [SEED_W-1:0] seed,
                                                input logic [PTR_W-1:0]  idx,
                                                input logic [WORD_W-1:0] val);
      return {7'd0, val, idx, seed};
   endfunction

   // present one request, with an optional random gap, and hold it until taken
   task automatic push_request(input logic [1:0] cmd, input logic [71:0] data);
      while (idling_on && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= data;
      @(posedge clock);
      while (req_tready !== 1'b1) begin
         @(posedge clock);
      end
      sent_total++;
   endtask

   task automatic seed_with(input logic [SEED_W-1:0] seed);
      seeds_sent++;
      push_request(CMD_SEED, pack_request(seed, PTR_W'($urandom), WORD_W'($urandom)));
   endtask

   task automatic draw_next();
      nexts_sent++;
      push_request(CMD_NEXT, pack_request(SEED_W'($urandom), PTR_W'($urandom),
                                          WORD_W'($urandom)));
   endtask

   task automatic dump_status();
      saves_sent++;
      push_request(CMD_SAVE, pack_request(SEED_W'($urandom), PTR_W'($urandom),
                                          WORD_W'($urandom)));
   endtask

   task automatic restore_slot(input logic [PTR_W-1:0] idx, input logic [WORD_W-1:0] val);
      restores_sent++;
      push_request(CMD_RESTORE, pack_request(SEED_W'($urandom), idx, val));
   endtask

   // withdraw the request and hold off until every predicted response has been seen
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_count != 0);
   endtask

   // random restore target and value, pointers and the wrap boundary favoured
   task automatic random_restore();
      int pick;
      logic [PTR_W-1:0]  idx;
      logic [WORD_W-1:0] val;
      pick = $urandom_range(99);
      if (pick < 70) begin
         idx = PTR_W'($urandom_range(TABLE_WORDS - 1));
      end else if (pick < 82) begin
         idx = SLOT_FIRST_PTR;
      end else if (pick < 94) begin
         idx = SLOT_SECOND_PTR;
      end else begin
         idx = PTR_W'($urandom_range(63, TABLE_WORDS + 2));
      end
      pick = $urandom_range(99);
      if (idx >= SLOT_FIRST_PTR && pick < 60) begin
         val = WORD_W'($urandom_range(63));
      end else if (pick < 15) begin
         val = WORD_W'($urandom_range(1000000005, 999999995));
      end else begin
         val = WORD_W'($urandom);
      end
      restore_slot(idx, val);
   endtask

   initial begin
      int pick;
      int run;
      seeds_sent = 0;
      nexts_sent = 0;
      saves_sent = 0;
      restores_sent = 0;
      sent_total = 0;

      // reset
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: next after reset, seed extremes, restore wraps and odd pointers
      draw_next();
      dump_status();
      seed_with('0);
      draw_next();
      draw_next();
      seed_with(SEED_W'(29'h0FFFFFFF));
      draw_next();
      seed_with(SEED_W'(29'h10000000));
      draw_next();
      seed_with(SEED_W'(161803398));
      draw_next();
      seed_with(SEED_W'(-161803398));
      seed_with(SEED_W'(-1));
      draw_next();
      restore_slot('0, WORD_W'(30'h3FFFFFFF));
      restore_slot(PTR_W'(TABLE_WORDS - 1), WORD_W'(999999999));
      restore_slot(PTR_W'(1), WORD_W'(1000000000));
      restore_slot(SLOT_FIRST_PTR, WORD_W'(TABLE_WORDS));
      restore_slot(SLOT_SECOND_PTR, WORD_W'(30'h3FFFFFFF));
      draw_next();
      restore_slot(SLOT_FIRST_PTR, '0);
      restore_slot(PTR_W'(TABLE_WORDS + 2), WORD_W'($urandom));
      restore_slot(PTR_W'(63), WORD_W'($urandom));
      draw_next();
      dump_status();

      // sender waits for the response stream to empty
      drain_responses();

      // random part, with a stretch free of gaps and stalls in the middle
      while (sent_total < RANDOM_ITEMS) begin
         idling_on = !(sent_total > 110 && sent_total < 170);
         pick = $urandom_range(99);
         if (pick < 5) begin
            if ($urandom_range(1) == 0) begin
               seed_with(SEED_W'($urandom));
            end else begin
               seed_with(SEED_W'($urandom_range(323606796) - 161803398));
            end
         end else if (pick < 60) begin
            run = $urandom_range(6, 1);
            repeat (run) draw_next();
         end else if (pick < 67) begin
            dump_status();
         end else if (pick < 68) begin
            drain_responses();
         end else begin
            random_restore();
         end
      end

      // let the last responses arrive and any seeding run out
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d requests: %0d seed, %0d next, %0d save, %0d restore",
               sent_total, seeds_sent, nexts_sent, saves_sent, restores_sent);
      $display("compared %0d responses, %0d mismatches", checked_count, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb_subtractive_random_generator OK");
      end else begin
         $display("tb_subtractive_random_generator NOT OK");
      end
      $finish;
   end

endmodule
